/* rtl/core/wfe_pkg.sv */
// Shared types and constants for the windowed feedback echo.
// No dependencies; used by the top level and the delay line memory.
package wfe_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int SEC_W      = 14;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int GAIN_FRAC  = 15;
    localparam int PROD_W     = SAMPLE_W + CFG_W + 1;
    localparam int ECHO_W     = PROD_W - GAIN_FRAC;
    localparam int SUM_W      = ECHO_W + 1;

    localparam logic [SEC_W-1:0]           SECOND_MAX = '1;
    localparam logic [CFG_W-1:0]           DELAY_RST  = 16'd22050;
    localparam logic [CFG_W-1:0]           GAIN_RST   = 16'd16384;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIN_START = 2'd0,
        CFG_WIN_END   = 2'd1,
        CFG_DELAY     = 2'd2,
        CFG_GAIN      = 2'd3
    } cfg_idx_t;

endpackage

/* rtl/core/wfe_delay_ram.sv */
// Simple dual-port delay line memory: one write and one registered read per cycle.
// Depends on wfe_pkg for the sample width.
module wfe_delay_ram #(
    parameter int DEPTH = 44100,
    parameter int AW    = 16
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [AW-1:0]                     waddr,
    input  logic [wfe_pkg::SAMPLE_W-1:0]      wdata,
    input  logic                              re,
    input  logic [AW-1:0]                     raddr,
    output logic [wfe_pkg::SAMPLE_W-1:0]      rdata
);

    logic [wfe_pkg::SAMPLE_W-1:0] mem [DEPTH];
    logic [wfe_pkg::SAMPLE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/windowed_feedback_echo.sv */
// Top level of the windowed feedback echo: counters, window check, delay line
// control, feedback multiply-add and output register. Depends on wfe_pkg and
// wfe_delay_ram.

// The block takes one signed 16-bit sample per request and returns one sample
// per request, in order, at a sustained rate of one sample per clock cycle while
// the output side is ready. An accepted sample is held in the second stage and
// then in the output register, from which it is taken when the output side is ready.
// The rate is set by the feedback loop through the delay line:
// the stored sample is read from the one-port-read memory at the edge of
// acceptance, and the multiply by the decay gain, the truncating shift, the add
// and the saturation all happen in the second stage, so that a result can be
// fed straight back to the next sample when the delay is a single sample. A
// sample counter splits the stream into seconds of SAMPLES_PER_SECOND samples,
// the first second numbered 1 and the count saturating at 16383. Inside the
// window (start < second <= end) the output is the input plus the decayed echo,
// and it is written into the delay line; outside the window the sample passes
// through and the delay line is untouched. The delay line starts out silent
// after reset without a clearing pass: the write pointer only ever advances
// through the memory in order, so an entry at or above the pointer that has not
// yet been passed by a wrap reads as zero. The block is ready right after reset.
// Configuration writes are taken at any edge with cfg_we high and should only be
// made while no request is in flight.
module windowed_feedback_echo #(
    parameter int SAMPLES_PER_SECOND = 44100
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write port.
    input  logic                               cfg_we,
    input  logic [wfe_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [wfe_pkg::CFG_W-1:0]          cfg_wdata,
    // Input stream.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [wfe_pkg::SAMPLE_W-1:0]       s_axis_tdata,   // [15:0] sample_in
    // Output stream.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [wfe_pkg::SAMPLE_W-1:0]       m_axis_tdata    // [15:0] sample_out
);

    // Address width of the delay line and width that can hold the length itself.
    localparam int AW = $clog2(SAMPLES_PER_SECOND);
    localparam int NW = $clog2(SAMPLES_PER_SECOND + 1);
    localparam int MW = (NW > wfe_pkg::CFG_W) ? NW : wfe_pkg::CFG_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(SAMPLES_PER_SECOND - 1);
    localparam logic [MW-1:0] N_EXT    = MW'(SAMPLES_PER_SECOND);

    // Configuration registers.
    logic [wfe_pkg::SEC_W-1:0] win_start_reg;
    logic [wfe_pkg::SEC_W-1:0] win_end_reg;
    logic [wfe_pkg::CFG_W-1:0] delay_reg;
    logic [wfe_pkg::CFG_W-1:0] gain_reg;

    // Stream position and delay line write pointer.
    logic [AW-1:0]             pos_reg;
    logic [wfe_pkg::SEC_W-1:0] sec_reg;
    logic [AW-1:0]             wi_reg;
    logic                      wrap_reg;

    // Second stage: the sample whose stored echo is being read.
    logic                              b_vld_reg;
    logic                              b_win_reg;
    logic                              b_fwd_reg;
    logic                              b_zero_reg;
    logic [AW-1:0]                     b_wi_reg;
    logic signed [wfe_pkg::SAMPLE_W-1:0] b_x_reg;

    // Last value written into the delay line, for read-during-write forwarding.
    logic signed [wfe_pkg::SAMPLE_W-1:0] last_wr_reg;

    // Output register.
    logic                          out_vld_reg;
    logic [wfe_pkg::SAMPLE_W-1:0]  out_data_reg;

    logic                          s_accept;
    logic                          b_adv;
    logic                          in_win;
    logic [MW-1:0]                 dly_ext;
    logic [MW-1:0]                 d_eff;
    logic [MW-1:0]                 wi_ext;
    logic [AW-1:0]                 rd_idx;
    logic                          rd_valid;
    logic                          rd_fwd;
    logic                          ram_we;
    logic [wfe_pkg::SAMPLE_W-1:0]  ram_rdata;

    logic signed [wfe_pkg::SAMPLE_W-1:0] fb_sample;
    logic signed [wfe_pkg::PROD_W-1:0]   prod;
    logic signed [wfe_pkg::PROD_W-1:0]   prod_adj;
    logic signed [wfe_pkg::ECHO_W-1:0]   echo;
    logic signed [wfe_pkg::SUM_W-1:0]    sum;
    logic signed [wfe_pkg::SAMPLE_W-1:0] y;

    // The second stage moves on whenever the output register is free or drained,
    // so a new sample is taken while a finished one still waits downstream.
    assign b_adv         = b_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !b_vld_reg || b_adv;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign in_win = (win_start_reg < sec_reg) && (sec_reg <= win_end_reg);

    // Effective delay: zero acts as one sample, anything beyond a second is a second.
    always_comb
    begin
        dly_ext = MW'(delay_reg);
        if (dly_ext == '0)
        begin
            d_eff = MW'(1);
        end
        else if (dly_ext > N_EXT)
        begin
            d_eff = N_EXT;
        end
        else
        begin
            d_eff = dly_ext;
        end
    end

    // Read index is the write pointer minus the delay, modulo the line length.
    always_comb
    begin
        wi_ext = MW'(wi_reg);
        if (wi_ext >= d_eff)
        begin
            rd_idx = AW'(wi_ext - d_eff);
        end
        else
        begin
            rd_idx = AW'(wi_ext + N_EXT - d_eff);
        end
    end

    // An entry holds data once the pointer has passed it at least once.
    assign rd_valid = wrap_reg || (rd_idx < wi_reg);

    // The sample ahead of this one writes the delay line at the very edge at
    // which this one reads it; the memory then returns stale data.
    assign rd_fwd = b_vld_reg && b_win_reg && (b_wi_reg == rd_idx);

    // Feedback arithmetic: multiply, truncate toward zero, add, saturate.
    always_comb
    begin
        if (b_fwd_reg)
        begin
            fb_sample = last_wr_reg;
        end
        else if (b_zero_reg)
        begin
            fb_sample = '0;
        end
        else
        begin
            fb_sample = signed'(ram_rdata);
        end
        prod = wfe_pkg::PROD_W'(fb_sample) * signed'({1'b0, gain_reg});
        if (prod < 0)
        begin
            prod_adj = prod + wfe_pkg::PROD_W'((1 << wfe_pkg::GAIN_FRAC) - 1);
        end
        else
        begin
            prod_adj = prod;
        end
        echo = wfe_pkg::ECHO_W'(prod_adj >>> wfe_pkg::GAIN_FRAC);
        sum  = wfe_pkg::SUM_W'(b_x_reg) + wfe_pkg::SUM_W'(echo);
        if (!b_win_reg)
        begin
            y = b_x_reg;
        end
        else if (sum > wfe_pkg::SUM_W'(wfe_pkg::SAMPLE_MAX))
        begin
            y = wfe_pkg::SAMPLE_MAX;
        end
        else if (sum < wfe_pkg::SUM_W'(wfe_pkg::SAMPLE_MIN))
        begin
            y = wfe_pkg::SAMPLE_MIN;
        end
        else
        begin
            y = wfe_pkg::SAMPLE_W'(sum);
        end
    end

    assign ram_we = b_adv && b_win_reg;

    wfe_delay_ram #(
        .DEPTH (SAMPLES_PER_SECOND),
        .AW    (AW)
    ) u_delay_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (b_wi_reg),
        .wdata (y),
        .re    (s_accept),
        .raddr (rd_idx),
        .rdata (ram_rdata)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_start_reg <= '0;
            win_end_reg   <= '0;
            delay_reg     <= wfe_pkg::DELAY_RST;
            gain_reg      <= wfe_pkg::GAIN_RST;
        end
        else if (cfg_we)
        begin
            case (wfe_pkg::cfg_idx_t'(cfg_addr))
                wfe_pkg::CFG_WIN_START: win_start_reg <= cfg_wdata[wfe_pkg::SEC_W-1:0];
                wfe_pkg::CFG_WIN_END:   win_end_reg   <= cfg_wdata[wfe_pkg::SEC_W-1:0];
                wfe_pkg::CFG_DELAY:     delay_reg     <= cfg_wdata;
                wfe_pkg::CFG_GAIN:      gain_reg      <= cfg_wdata;
                default:                ;
            endcase
        end
    end

    // Stream position, write pointer and pipeline control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            sec_reg     <= wfe_pkg::SEC_W'(1);
            wi_reg      <= '0;
            wrap_reg    <= 1'b0;
            b_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (s_accept)
            begin
                if (pos_reg == LAST_IDX)
                begin
                    pos_reg <= '0;
                    if (sec_reg != wfe_pkg::SECOND_MAX)
                    begin
                        sec_reg <= sec_reg + wfe_pkg::SEC_W'(1);
                    end
                end
                else
                begin
                    pos_reg <= pos_reg + AW'(1);
                end
                if (in_win)
                begin
                    if (wi_reg == LAST_IDX)
                    begin
                        wi_reg   <= '0;
                        wrap_reg <= 1'b1;
                    end
                    else
                    begin
                        wi_reg <= wi_reg + AW'(1);
                    end
                end
            end
            if (s_accept)
            begin
                b_vld_reg <= 1'b1;
            end
            else if (b_adv)
            begin
                b_vld_reg <= 1'b0;
            end
            if (b_adv)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            b_win_reg  <= in_win;
            b_fwd_reg  <= rd_fwd;
            b_zero_reg <= !rd_valid;
            b_wi_reg   <= wi_reg;
            b_x_reg    <= signed'(s_axis_tdata);
        end
        if (ram_we)
        begin
            last_wr_reg <= y;
        end
        if (b_adv)
        begin
            out_data_reg <= y;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

    // A forwarded echo must come from a write made at the edge of acceptance.
    a_fwd_follows_write: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> (!b_fwd_reg || $past(ram_we)))
        else $error("forwarded echo without a matching delay line write");

    // The delay line is only written for a windowed sample leaving stage two.
    a_write_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (b_vld_reg && b_win_reg && b_adv))
        else $error("delay line written without a windowed sample");

    // With stage two empty a request must always be taken.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !b_vld_reg |-> s_axis_tready)
        else $error("input stalled with an empty pipeline");

    // The second counter starts at one and never falls back to zero.
    a_second_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        sec_reg != '0)
        else $error("second counter reached zero");

endmodule
